// ----- rtl/hfs_pkg.sv -----
`timescale 1ns / 1ps

package hfs_pkg;

   // Parser phases
   typedef enum logic [3:0] {
      PH_LEAD,
      PH_SIGN,
      PH_ZERO,
      PH_MANT,
      PH_PEXP,
      PH_ESGN,
      PH_EDIG,
      PH_SUFF,
      PH_TRAIL,
      PH_ERR
   } phase_type;

   // Counter widths and limits
   localparam int unsigned EXP_W   = 24;
   localparam int unsigned POS_W   = 24;
   localparam int unsigned LEN_W   = 7;
   localparam int unsigned E_W     = 27;
   localparam int unsigned FRAME_W = 64;
   localparam int unsigned POS_SAT = 8388607;
   localparam logic [EXP_W-1:0] EXP_SAT = '1;

   // IEEE formats
   localparam int unsigned VAL_W    = 64;
   localparam int unsigned SGL_W    = 32;
   localparam int unsigned DBL_MW   = 52;
   localparam int unsigned DBL_EW   = 11;
   localparam int unsigned DBL_BIAS = 1023;
   localparam int unsigned DBL_EMAX = 2047;
   localparam int unsigned SGL_MW   = 23;
   localparam int unsigned SGL_EW   = 8;
   localparam int unsigned SGL_BIAS = 127;
   localparam int unsigned SGL_EMAX = 255;
   localparam int unsigned M_W      = DBL_MW + 2;

   // Parsed literal, captured on the final character
   typedef struct packed {
      logic             err;
      logic             neg;
      logic             nonzero;
      logic             sticky;
      logic             dbl;
      logic [EXP_W-1:0] exp_acc;
      logic             exp_neg;
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] len;
   } snap_type;

   // Unbiased-plus-bias exponent stage
   typedef struct packed {
      logic             err;
      logic             neg;
      logic             nonzero;
      logic             sticky;
      logic             dbl;
      logic [E_W-1:0]   e;
      logic [LEN_W-1:0] len;
   } expo_type;

   // Classified value with alignment shift
   typedef struct packed {
      logic              err;
      logic              neg;
      logic              dbl;
      logic              inf;
      logic              zero;
      logic              sticky;
      logic [DBL_EW-1:0] e_adj;
      logic [LEN_W-1:0]  rsh;
   } align_type;

   // Aligned mantissa with guard bit, ready to round
   typedef struct packed {
      logic              err;
      logic              neg;
      logic              dbl;
      logic              inf;
      logic              zero;
      logic              sticky;
      logic [DBL_EW-1:0] e_adj;
      logic [M_W-1:0]    man;
   } frac_type;

endpackage

// ----- rtl/hfs_parse.sv -----
`timescale 1ns / 1ps

module hfs_parse #(
   parameter int unsigned SIG_DIGITS = 15
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                char_code,
   input  logic                      last_char,
   input  logic                      double_mode,
   output logic                      snap_valid,
   input  logic                      snap_ready,
   output hfs_pkg::snap_type         snap,
   output logic [4*SIG_DIGITS-1:0]   snap_sig
);

   localparam int unsigned SIG_W = 4 * SIG_DIGITS;
   localparam int unsigned CNT_W = $clog2(SIG_DIGITS + 1);
   localparam int unsigned PX_W  = hfs_pkg::POS_W + 2;
   localparam logic signed [PX_W-1:0] POS_HI = PX_W'(hfs_pkg::POS_SAT);
   localparam logic signed [PX_W-1:0] POS_LO = -POS_HI;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_D_UP  = 8'h44;
   localparam logic [7:0] CH_F_UP  = 8'h46;
   localparam logic [7:0] CH_P_UP  = 8'h50;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_D_LO  = 8'h64;
   localparam logic [7:0] CH_F_LO  = 8'h66;
   localparam logic [7:0] CH_P_LO  = 8'h70;
   localparam logic [7:0] CH_X_LO  = 8'h78;

   // Clamp a widened position to the saturation bounds
   function automatic logic [hfs_pkg::POS_W-1:0] pos_sat(input logic [PX_W-1:0] v);
      logic signed [PX_W-1:0] s;
      s = $signed(v);
      if (s > POS_HI) return hfs_pkg::POS_W'(POS_HI);
      if (s < POS_LO) return hfs_pkg::POS_W'(POS_LO);
      return v[hfs_pkg::POS_W-1:0];
   endfunction

   hfs_pkg::phase_type          phase_ff, phase_in;
   logic                        neg_ff, neg_in;
   logic [SIG_W-1:0]            sig_ff, sig_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [hfs_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                        sticky_ff, sticky_in;
   logic [hfs_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        pt_ff, pt_in;
   logic                        dig_ff, dig_in;
   logic                        nz_ff, nz_in;
   logic [hfs_pkg::EXP_W-1:0]   acc_ff, acc_in;
   logic                        eneg_ff, eneg_in;
   logic                        snap_v_ff;
   hfs_pkg::snap_type           snap_ff, snap_in;
   logic [SIG_W-1:0]            snap_sig_ff;

   logic       ws, dec, hex_lo, hex_hi, is_hex, sign_ch, suffix_ch, take_digit, accept;
   logic [3:0] digit;
   logic [1:0] msb_pos;
   logic [PX_W-1:0] pos_x;
   logic [hfs_pkg::EXP_W+3:0] acc10;

   // Classify the character
   assign ws        = char_code <= CH_SPACE;
   assign dec       = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign hex_lo    = (char_code >= CH_A_LO) && (char_code <= CH_F_LO);
   assign hex_hi    = (char_code >= CH_A_UP) && (char_code <= CH_F_UP);
   assign is_hex    = dec || hex_lo || hex_hi;
   assign digit     = dec ? char_code[3:0] : char_code[3:0] + 4'd9;
   assign sign_ch   = (char_code == CH_PLUS) || (char_code == CH_MINUS);
   assign suffix_ch = (char_code == CH_F_LO) || (char_code == CH_F_UP) ||
                      (char_code == CH_D_LO) || (char_code == CH_D_UP);
   assign msb_pos   = digit[3] ? 2'd3 : digit[2] ? 2'd2 : digit[1] ? 2'd1 : 2'd0;
   assign take_digit = (phase_ff == hfs_pkg::PH_MANT) && is_hex;
   assign pos_x     = PX_W'($signed(pos_ff));
   assign acc10     = (hfs_pkg::EXP_W+4)'({acc_ff, 3'b000}) +
                      (hfs_pkg::EXP_W+4)'({acc_ff, 1'b0}) +
                      (hfs_pkg::EXP_W+4)'(char_code[3:0]);

   // Phase transitions, sign and exponent digits
   always_comb begin
      phase_in = hfs_pkg::PH_ERR;
      neg_in   = neg_ff;
      pt_in    = pt_ff;
      acc_in   = acc_ff;
      eneg_in  = eneg_ff;
      case (phase_ff)
         hfs_pkg::PH_LEAD: begin
            if (ws) begin
               phase_in = hfs_pkg::PH_LEAD;
            end else if (sign_ch) begin
               neg_in   = char_code == CH_MINUS;
               phase_in = hfs_pkg::PH_SIGN;
            end else if (char_code == CH_ZERO) begin
               phase_in = hfs_pkg::PH_ZERO;
            end
         end
         hfs_pkg::PH_SIGN: begin
            if (char_code == CH_ZERO) phase_in = hfs_pkg::PH_ZERO;
         end
         hfs_pkg::PH_ZERO: begin
            if ((char_code == CH_X_LO) || (char_code == CH_X_UP)) phase_in = hfs_pkg::PH_MANT;
         end
         hfs_pkg::PH_MANT: begin
            if (is_hex) begin
               phase_in = hfs_pkg::PH_MANT;
            end else if ((char_code == CH_DOT) && !pt_ff) begin
               pt_in    = 1'b1;
               phase_in = hfs_pkg::PH_MANT;
            end else if (((char_code == CH_P_LO) || (char_code == CH_P_UP)) && dig_ff) begin
               phase_in = hfs_pkg::PH_PEXP;
            end
         end
         hfs_pkg::PH_PEXP, hfs_pkg::PH_ESGN, hfs_pkg::PH_EDIG: begin
            if (dec) begin
               acc_in   = (acc10 > (hfs_pkg::EXP_W+4)'(hfs_pkg::EXP_SAT)) ?
                          hfs_pkg::EXP_SAT : acc10[hfs_pkg::EXP_W-1:0];
               phase_in = hfs_pkg::PH_EDIG;
            end else if ((phase_ff == hfs_pkg::PH_PEXP) && sign_ch) begin
               eneg_in  = char_code == CH_MINUS;
               phase_in = hfs_pkg::PH_ESGN;
            end else if (phase_ff == hfs_pkg::PH_EDIG) begin
               if (suffix_ch) phase_in = hfs_pkg::PH_SUFF;
               else if (ws) phase_in = hfs_pkg::PH_TRAIL;
            end
         end
         hfs_pkg::PH_SUFF, hfs_pkg::PH_TRAIL: begin
            if (ws) phase_in = hfs_pkg::PH_TRAIL;
         end
         default: phase_in = hfs_pkg::PH_ERR;
      endcase
   end

   // Significand digits: skip leading zeros, keep a bounded count, fold the rest
   always_comb begin
      sig_in    = sig_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      sticky_in = sticky_ff;
      pos_in    = pos_ff;
      dig_in    = dig_ff;
      nz_in     = nz_ff;
      if (take_digit) begin
         dig_in = 1'b1;
         if (!nz_ff) begin
            if (digit == 4'd0) begin
               if (pt_ff) pos_in = pos_sat(pos_x - PX_W'(4));
            end else begin
               nz_in  = 1'b1;
               pos_in = pt_ff ? pos_sat(pos_x + PX_W'(msb_pos) - PX_W'(4))
                              : hfs_pkg::POS_W'(msb_pos);
               sig_in = SIG_W'(digit);
               cnt_in = CNT_W'(1);
               len_in = hfs_pkg::LEN_W'(msb_pos) + hfs_pkg::LEN_W'(1);
            end
         end else begin
            if (!pt_ff) pos_in = pos_sat(pos_x + PX_W'(4));
            if (cnt_ff < CNT_W'(SIG_DIGITS)) begin
               sig_in = {sig_ff[SIG_W-5:0], digit};
               cnt_in = cnt_ff + CNT_W'(1);
               len_in = len_ff + hfs_pkg::LEN_W'(4);
            end else if (digit != 4'd0) begin
               sticky_in = 1'b1;
            end
         end
      end
   end

   // Snapshot of the finished literal
   always_comb begin
      snap_in.err     = !((phase_in == hfs_pkg::PH_EDIG) || (phase_in == hfs_pkg::PH_SUFF) ||
                          (phase_in == hfs_pkg::PH_TRAIL));
      snap_in.neg     = neg_in;
      snap_in.nonzero = nz_in;
      snap_in.sticky  = sticky_in;
      snap_in.dbl     = double_mode;
      snap_in.exp_acc = acc_in;
      snap_in.exp_neg = eneg_in;
      snap_in.pos     = pos_in;
      snap_in.len     = len_in;
   end

   assign req_ready = !snap_v_ff || snap_ready;
   assign accept    = req_valid && req_ready;

   // Advance the parse state; clear it after the final character
   always_ff @(posedge clock) begin
      if (reset || (accept && last_char)) begin
         phase_ff  <= hfs_pkg::PH_LEAD;
         neg_ff    <= 1'b0;
         sig_ff    <= '0;
         cnt_ff    <= '0;
         len_ff    <= '0;
         sticky_ff <= 1'b0;
         pos_ff    <= '0;
         pt_ff     <= 1'b0;
         dig_ff    <= 1'b0;
         nz_ff     <= 1'b0;
         acc_ff    <= '0;
         eneg_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         sig_ff    <= sig_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
         sticky_ff <= sticky_in;
         pos_ff    <= pos_in;
         pt_ff     <= pt_in;
         dig_ff    <= dig_in;
         nz_ff     <= nz_in;
         acc_ff    <= acc_in;
         eneg_ff   <= eneg_in;
      end
   end

   // Snapshot register toward the exponent stage
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_v_ff <= 1'b0;
      end else if (req_ready) begin
         snap_v_ff <= accept && last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_char) begin
         snap_ff     <= snap_in;
         snap_sig_ff <= sig_in;
      end
   end

   assign snap_valid = snap_v_ff;
   assign snap       = snap_ff;
   assign snap_sig   = snap_sig_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last_char) |=> (phase_ff == hfs_pkg::PH_LEAD) && !nz_ff && (cnt_ff == '0))
      else $error("parse state not cleared after final character");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SIG_DIGITS))
      else $error("kept digit count beyond bound");

endmodule

// ----- rtl/hfs_align.sv -----
`timescale 1ns / 1ps

module hfs_align #(
   parameter int unsigned SIG_DIGITS = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     snap_valid,
   output logic                     snap_ready,
   input  hfs_pkg::snap_type        snap,
   input  logic [4*SIG_DIGITS-1:0]  snap_sig,
   output logic                     al_valid,
   input  logic                     al_ready,
   output hfs_pkg::align_type       al,
   output logic [4*SIG_DIGITS-1:0]  al_sig
);

   localparam int unsigned SIG_W = 4 * SIG_DIGITS;
   localparam int unsigned E_W   = hfs_pkg::E_W;

   logic                 x1_v_ff, x2_v_ff, x1_rdy, x2_rdy;
   hfs_pkg::expo_type    x1_ff, x1_in;
   hfs_pkg::align_type   x2_ff, x2_in;
   logic [SIG_W-1:0]     x1_sig_ff, x2_sig_ff;

   logic [E_W-1:0]        acc_x, pos_x, bias_x;
   logic signed [E_W-1:0] es, emax_s, ulim_s;
   logic                  sub;
   logic [6:0]            mw7, desired;
   logic [7:0]            rsh8;

   // Biased exponent: signed decimal exponent plus leading-bit position plus bias
   always_comb begin
      acc_x  = E_W'(snap.exp_acc);
      pos_x  = E_W'($signed(snap.pos));
      bias_x = snap.dbl ? E_W'(hfs_pkg::DBL_BIAS) : E_W'(hfs_pkg::SGL_BIAS);
      x1_in.err     = snap.err;
      x1_in.neg     = snap.neg;
      x1_in.nonzero = snap.nonzero;
      x1_in.sticky  = snap.sticky;
      x1_in.dbl     = snap.dbl;
      x1_in.e       = (snap.exp_neg ? (E_W'(0) - acc_x) : acc_x) + pos_x + bias_x;
      x1_in.len     = snap.len;
   end

   // Classify range and work out the alignment shift
   always_comb begin
      es      = $signed(x1_ff.e);
      emax_s  = x1_ff.dbl ? E_W'(hfs_pkg::DBL_EMAX) : E_W'(hfs_pkg::SGL_EMAX);
      ulim_s  = x1_ff.dbl ? -$signed(E_W'(hfs_pkg::DBL_MW + 1))
                          : -$signed(E_W'(hfs_pkg::SGL_MW + 1));
      mw7     = x1_ff.dbl ? 7'(hfs_pkg::DBL_MW) : 7'(hfs_pkg::SGL_MW);
      sub     = es < $signed(E_W'(1));
      desired = sub ? (mw7 + 7'd1 + x1_ff.e[6:0]) : (mw7 + 7'd2);
      rsh8    = 8'(hfs_pkg::FRAME_W) - {1'b0, desired} + {1'b0, x1_ff.len};
      x2_in.err    = x1_ff.err;
      x2_in.neg    = x1_ff.neg;
      x2_in.dbl    = x1_ff.dbl;
      x2_in.inf    = x1_ff.nonzero && (es >= emax_s);
      x2_in.zero   = !x1_ff.nonzero || (es <= ulim_s);
      x2_in.sticky = x1_ff.sticky;
      x2_in.e_adj  = sub ? '0 : (x1_ff.e[hfs_pkg::DBL_EW-1:0] - hfs_pkg::DBL_EW'(1));
      x2_in.rsh    = rsh8[hfs_pkg::LEN_W-1:0];
   end

   assign x2_rdy     = !x2_v_ff || al_ready;
   assign x1_rdy     = !x1_v_ff || x2_rdy;
   assign snap_ready = x1_rdy;

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_v_ff <= 1'b0;
         x2_v_ff <= 1'b0;
      end else begin
         if (x1_rdy) x1_v_ff <= snap_valid;
         if (x2_rdy) x2_v_ff <= x1_v_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (x1_rdy && snap_valid) begin
         x1_ff     <= x1_in;
         x1_sig_ff <= snap_sig;
      end
      if (x2_rdy && x1_v_ff) begin
         x2_ff     <= x2_in;
         x2_sig_ff <= x1_sig_ff;
      end
   end

   assign al_valid = x2_v_ff;
   assign al       = x2_ff;
   assign al_sig   = x2_sig_ff;

endmodule

// ----- rtl/hfs_round.sv -----
`timescale 1ns / 1ps

module hfs_round #(
   parameter int unsigned SIG_DIGITS = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         al_valid,
   output logic                         al_ready,
   input  hfs_pkg::align_type           al,
   input  logic [4*SIG_DIGITS-1:0]      al_sig,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hfs_pkg::VAL_W-1:0]    value_bits,
   output logic                         format_error
);

   localparam int unsigned WIDE_W = 2 * hfs_pkg::FRAME_W;
   localparam int unsigned M_W    = hfs_pkg::M_W;
   localparam int unsigned DF_W   = hfs_pkg::VAL_W - 1;
   localparam int unsigned SF_W   = hfs_pkg::SGL_W - 1;

   logic                        fr_v_ff, out_v_ff, fr_rdy, out_rdy;
   hfs_pkg::frac_type           fr_ff, fr_in;
   logic [hfs_pkg::VAL_W-1:0]   val_ff, val_in;
   logic                        err_ff, dbl_ff;

   logic [WIDE_W-1:0] wide, shifted, low_mask;
   logic [M_W-2:0]    q;
   logic              up;
   logic [M_W-1:0]    mr;
   logic [DF_W-1:0]   dfield;
   logic [SF_W-1:0]   sfield;

   // Align the kept significand to the target width; fold shifted-out bits
   always_comb begin
      wide     = {hfs_pkg::FRAME_W'(al_sig), {hfs_pkg::FRAME_W{1'b0}}};
      shifted  = wide >> al.rsh;
      low_mask = ~({WIDE_W{1'b1}} << al.rsh);
      fr_in.err    = al.err;
      fr_in.neg    = al.neg;
      fr_in.dbl    = al.dbl;
      fr_in.inf    = al.inf;
      fr_in.zero   = al.zero;
      fr_in.sticky = al.sticky || (|(wide & low_mask));
      fr_in.e_adj  = al.e_adj;
      fr_in.man    = shifted[M_W-1:0];
   end

   // Round half to even and pack; a mantissa carry lands in the exponent field
   always_comb begin
      q      = fr_ff.man[M_W-1:1];
      up     = fr_ff.man[0] && (fr_ff.sticky || fr_ff.man[1]);
      mr     = {1'b0, q} + M_W'(up);
      dfield = (DF_W'(fr_ff.e_adj) << hfs_pkg::DBL_MW) + DF_W'(mr);
      sfield = (SF_W'(fr_ff.e_adj[hfs_pkg::SGL_EW-1:0]) << hfs_pkg::SGL_MW) + SF_W'(mr);
      if (fr_ff.err) begin
         val_in = '0;
      end else if (fr_ff.dbl) begin
         if (fr_ff.inf) begin
            val_in = {fr_ff.neg, {hfs_pkg::DBL_EW{1'b1}}, {hfs_pkg::DBL_MW{1'b0}}};
         end else if (fr_ff.zero) begin
            val_in = {fr_ff.neg, {DF_W{1'b0}}};
         end else begin
            val_in = {fr_ff.neg, dfield};
         end
      end else begin
         if (fr_ff.inf) begin
            val_in = {{hfs_pkg::SGL_W{1'b0}}, fr_ff.neg, {hfs_pkg::SGL_EW{1'b1}},
                      {hfs_pkg::SGL_MW{1'b0}}};
         end else if (fr_ff.zero) begin
            val_in = {{hfs_pkg::SGL_W{1'b0}}, fr_ff.neg, {SF_W{1'b0}}};
         end else begin
            val_in = {{hfs_pkg::SGL_W{1'b0}}, fr_ff.neg, sfield};
         end
      end
   end

   assign out_rdy  = !out_v_ff || rsp_ready;
   assign fr_rdy   = !fr_v_ff || out_rdy;
   assign al_ready = fr_rdy;

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         fr_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (fr_rdy) fr_v_ff <= al_valid;
         if (out_rdy) out_v_ff <= fr_v_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (fr_rdy && al_valid) fr_ff <= fr_in;
      if (out_rdy && fr_v_ff) begin
         val_ff <= val_in;
         err_ff <= fr_ff.err;
         dbl_ff <= fr_ff.dbl;
      end
   end

   assign rsp_valid    = out_v_ff;
   assign value_bits   = val_ff;
   assign format_error = err_ff;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && err_ff) |-> (val_ff == '0))
      else $error("error word carries nonzero value");

   a_single_high_clear: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !dbl_ff) |-> (val_ff[hfs_pkg::VAL_W-1:hfs_pkg::SGL_W] == '0))
      else $error("single-precision word has upper bits set");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (fr_v_ff && out_rdy) |=> out_v_ff)
      else $error("rounded word lost between stages");

endmodule

// ----- rtl/hex_float_string_to_bits.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Ports                         Payload
// req       in         req_tvalid/tready/tdata/tlast  one character, tlast on the final one
// rsp       out        rsp_tvalid/tready/tdata/tuser  IEEE word, tuser flags a bad literal
// csr       in         csr_wr_en/csr_wr_data          double_mode (1 = binary64)
//
// One character is accepted every cycle that req_tready is high and updates the parse
// registers; the final one also yields a word that passes through snapshot, exponent,
// classify, align and round registers before it appears on rsp_tvalid.
// reset is synchronous and clears all parse state and every stage valid;
// double_mode resets to 1. Characters keep flowing while rsp is stalled until
// all five result registers hold words not yet taken; then req_tready drops.

module hex_float_string_to_bits #(
   parameter int unsigned SIG_DIGITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_code
   input  logic        req_tlast,    // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [63:0] value_bits
   output logic        rsp_tuser,    // format_error
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int unsigned SIG_W = 4 * SIG_DIGITS;

   logic                 dbl_ff;
   logic                 snap_valid, snap_ready, al_valid, al_ready;
   hfs_pkg::snap_type    snap;
   hfs_pkg::align_type   al;
   logic [SIG_W-1:0]     snap_sig, al_sig;

   // Format select register
   always_ff @(posedge clock) begin
      if (reset) begin
         dbl_ff <= 1'b1;
      end else if (csr_wr_en) begin
         dbl_ff <= csr_wr_data;
      end
   end

   hfs_parse #(.SIG_DIGITS(SIG_DIGITS)) u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .char_code   (req_tdata),
      .last_char   (req_tlast),
      .double_mode (dbl_ff),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap        (snap),
      .snap_sig    (snap_sig)
   );

   hfs_align #(.SIG_DIGITS(SIG_DIGITS)) u_align (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .snap_sig   (snap_sig),
      .al_valid   (al_valid),
      .al_ready   (al_ready),
      .al         (al),
      .al_sig     (al_sig)
   );

   hfs_round #(.SIG_DIGITS(SIG_DIGITS)) u_round (
      .clock        (clock),
      .reset        (reset),
      .al_valid     (al_valid),
      .al_ready     (al_ready),
      .al           (al),
      .al_sig       (al_sig),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .value_bits   (rsp_tdata),
      .format_error (rsp_tuser)
   );

endmodule

// ----- tb/hex_float_string_to_bits_tb.sv -----
`timescale 1ns / 1ps

module hex_float_string_to_bits_tb;

   localparam int SIG_DIGITS  = 15;
   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      logic [7:0] code;
      logic       is_last;
   } lit_char_type;

   typedef struct {
      logic [63:0] bits;
      logic        bad;
   } ieee_word_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;    // [7:0] char_code
   logic        req_tlast   = 1'b0;  // last_char
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;           // [63:0] value_bits
   logic        rsp_tuser;           // format_error
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   hex_float_string_to_bits i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   lit_char_type  pending_chars[$];
   ieee_word_type expected_words[$];
   logic [7:0]    draft[$];

   int            mismatches   = 0;
   int            send_gap     = 0;
   int            send_calm    = 0;
   int            recv_stall   = 0;
   int            recv_calm    = 0;
   int            quiet_cycles = 0;
   lit_char_type  send_next;
   ieee_word_type want;

   // Shadow of the format register and of the literal being parsed
   logic               fp_double    = 1'b1;
   hfs_pkg::phase_type lit_phase    = hfs_pkg::PH_LEAD;
   logic               lit_neg      = 1'b0;
   logic [63:0]        lit_sig      = '0;
   int                 lit_ndig     = 0;
   logic               lit_sticky   = 1'b0;
   int                 lit_pos      = 0;
   logic               seen_point   = 1'b0;
   logic               seen_digit   = 1'b0;
   logic               seen_nonzero = 1'b0;
   longint             lit_exp      = 0;
   logic               lit_exp_neg  = 1'b0;

   function automatic int msb_count(logic [63:0] v);
      int n;
      n = 0;
      while (v != 0) begin
         n++;
         v >>= 1;
      end
      return n;
   endfunction

   function automatic int clamp_pos(int v);
      if (v > int'(hfs_pkg::POS_SAT)) return int'(hfs_pkg::POS_SAT);
      if (v < -int'(hfs_pkg::POS_SAT)) return -int'(hfs_pkg::POS_SAT);
      return v;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
   endfunction

   task automatic clear_literal();
      lit_phase    = hfs_pkg::PH_LEAD;
      lit_neg      = 1'b0;
      lit_sig      = '0;
      lit_ndig     = 0;
      lit_sticky   = 1'b0;
      lit_pos      = 0;
      seen_point   = 1'b0;
      seen_digit   = 1'b0;
      seen_nonzero = 1'b0;
      lit_exp      = 0;
      lit_exp_neg  = 1'b0;
   endtask

   // Keep the first SIG_DIGITS digits from the leading nonzero one, fold the rest into sticky
   task automatic take_digit(int d);
      seen_digit = 1'b1;
      if (!seen_nonzero) begin
         if (d == 0) begin
            if (seen_point) lit_pos = clamp_pos(lit_pos - 4);
         end else begin
            seen_nonzero = 1'b1;
            if (seen_point) lit_pos = clamp_pos(lit_pos - 4 + msb_count(64'(d)) - 1);
            else lit_pos = msb_count(64'(d)) - 1;
            lit_sig  = 64'(d);
            lit_ndig = 1;
         end
      end else begin
         if (!seen_point) lit_pos = clamp_pos(lit_pos + 4);
         if (lit_ndig < SIG_DIGITS) begin
            lit_sig = (lit_sig << 4) | 64'(d);
            lit_ndig++;
         end else if (d != 0) begin
            lit_sticky = 1'b1;
         end
      end
   endtask

   // Normalize, round half to even and pack in the selected format
   function automatic logic [63:0] ieee_word();
      int          mw;
      int          ew;
      longint      bias;
      longint      emax;
      longint      e;
      logic [63:0] mask;
      logic [63:0] sign;
      logic [63:0] m;
      logic        sticky;
      logic        lastbit;
      int          desired;
      int          len;
      int          drop;
      int          oldl;
      int          newl;
      mw     = fp_double ? hfs_pkg::DBL_MW : hfs_pkg::SGL_MW;
      ew     = fp_double ? hfs_pkg::DBL_EW : hfs_pkg::SGL_EW;
      bias   = fp_double ? hfs_pkg::DBL_BIAS : hfs_pkg::SGL_BIAS;
      emax   = fp_double ? hfs_pkg::DBL_EMAX : hfs_pkg::SGL_EMAX;
      mask   = (64'd1 << mw) - 64'd1;
      sign   = 64'(lit_neg) << (mw + ew);
      sticky = lit_sticky;
      if (!seen_nonzero) return sign;
      e = lit_exp_neg ? -lit_exp : lit_exp;
      e = e + bias + lit_pos;
      if (e >= emax) return sign | (64'(emax) << mw);
      if (e <= -(mw + 1)) return sign;
      if (e >= 1) begin
         desired = mw + 2;
      end else begin
         desired = mw + 1 + int'(e);
         e = 0;
      end
      m   = lit_sig;
      len = msb_count(m);
      if (len > desired) begin
         drop = len - desired;
         if ((m & ((64'd1 << drop) - 64'd1)) != 0) sticky = 1'b1;
         m = m >> drop;
      end else begin
         m = m << (desired - len);
      end
      lastbit = m[0];
      m = m >> 1;
      if (lastbit && (sticky || m[0])) begin
         oldl = msb_count(m);
         m    = m + 64'd1;
         newl = msb_count(m);
         if (oldl >= mw && newl > oldl) e = e + 1;
      end
      m = m & mask;
      return sign | (64'(e) << mw) | m;
   endfunction

   // Advance the parse on one accepted character; on the final character queue the result
   task automatic scan_char(logic [7:0] c, logic is_last);
      logic               ws;
      logic               dec;
      int                 hv;
      longint             acc;
      hfs_pkg::phase_type nx;
      ws  = (c <= 8'd32);
      dec = (c >= "0" && c <= "9");
      hv  = hex_digit(c);
      nx  = hfs_pkg::PH_ERR;
      case (lit_phase)
         hfs_pkg::PH_LEAD: begin
            if (ws) nx = hfs_pkg::PH_LEAD;
            else if (c == "+" || c == "-") begin
               lit_neg = (c == "-");
               nx = hfs_pkg::PH_SIGN;
            end else if (c == "0") nx = hfs_pkg::PH_ZERO;
         end
         hfs_pkg::PH_SIGN: if (c == "0") nx = hfs_pkg::PH_ZERO;
         hfs_pkg::PH_ZERO: if (c == "x" || c == "X") nx = hfs_pkg::PH_MANT;
         hfs_pkg::PH_MANT: begin
            if (hv >= 0) begin
               take_digit(hv);
               nx = hfs_pkg::PH_MANT;
            end else if (c == "." && !seen_point) begin
               seen_point = 1'b1;
               nx = hfs_pkg::PH_MANT;
            end else if ((c == "p" || c == "P") && seen_digit) nx = hfs_pkg::PH_PEXP;
         end
         hfs_pkg::PH_PEXP, hfs_pkg::PH_ESGN, hfs_pkg::PH_EDIG: begin
            if (dec) begin
               acc = lit_exp * 10 + longint'(c - "0");
               lit_exp = (acc > longint'(hfs_pkg::EXP_SAT)) ? longint'(hfs_pkg::EXP_SAT) : acc;
               nx = hfs_pkg::PH_EDIG;
            end else if (lit_phase == hfs_pkg::PH_PEXP && (c == "+" || c == "-")) begin
               lit_exp_neg = (c == "-");
               nx = hfs_pkg::PH_ESGN;
            end else if (lit_phase == hfs_pkg::PH_EDIG) begin
               if (c == "f" || c == "F" || c == "d" || c == "D") nx = hfs_pkg::PH_SUFF;
               else if (ws) nx = hfs_pkg::PH_TRAIL;
            end
         end
         hfs_pkg::PH_SUFF, hfs_pkg::PH_TRAIL: if (ws) nx = hfs_pkg::PH_TRAIL;
         default: ;
      endcase
      lit_phase = nx;
      if (is_last) begin
         if (lit_phase == hfs_pkg::PH_EDIG || lit_phase == hfs_pkg::PH_SUFF ||
             lit_phase == hfs_pkg::PH_TRAIL)
            expected_words.push_back('{ieee_word(), 1'b0});
         else
            expected_words.push_back('{64'd0, 1'b1});
         clear_literal();
      end
   endtask

   // Mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Send characters from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) scan_char(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
               send_next = pending_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= send_next.code;
               req_tlast  <= send_next.is_last;
               send_gap = pick_gap(send_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Check result words, stall the receiver, and watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: value_bits %h format_error %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata !== want.bits) begin
                  $display("%0t: value_bits expected %h got %h", $time, want.bits, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== want.bad) begin
                  $display("%0t: format_error expected %b got %b", $time, want.bad, rsp_tuser);
                  mismatches++;
               end
            end
         end

         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if ((rsp_tvalid && rsp_tready) || $urandom_range(0, 7) == 0) begin
            recv_stall = pick_gap(recv_calm);
            rsp_tready <= (recv_stall == 0);
         end else begin
            rsp_tready <= 1'b1;
         end

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("hex_float_string_to_bits regression: fail");
            $finish;
         end
      end
   end

   task automatic put_text(string t);
      for (int i = 0; i < t.len(); i++) draft.push_back(t[i]);
   endtask

   task automatic put_hex(int v);
      if (v < 10) draft.push_back(8'(48 + v));
      else draft.push_back(8'(($urandom_range(0, 1) ? 65 : 97) + v - 10));
   endtask

   // Hex digit run: plain random, all F for round carries, or mostly zero for ties
   task automatic put_digits(int n);
      int style;
      style = $urandom_range(0, 5);
      repeat (n) begin
         if (style == 0) put_hex(15);
         else if (style == 1) put_hex(($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0);
         else put_hex(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
      end
   endtask

   function automatic int digit_run();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 4);
      if (r < 92) return $urandom_range(5, 12);
      return $urandom_range(13, 22);
   endfunction

   // Hand the drafted literal to the driver, last flag on its final character
   task automatic commit();
      for (int i = 0; i < draft.size(); i++)
         pending_chars.push_back('{draft[i], i == draft.size() - 1});
      draft.delete();
   endtask

   // Draft a well-formed literal; exponents are small, near the format's edges, or far beyond them
   task automatic draft_literal(logic dbl);
      int   nint;
      int   nfrac;
      int   kind;
      logic pointed;
      repeat ($urandom_range(0, 2)) draft.push_back(8'($urandom_range(0, 32)));
      case ($urandom_range(0, 2))
         1: put_text("+");
         2: put_text("-");
         default: ;
      endcase
      put_text($urandom_range(0, 1) ? "0x" : "0X");
      nint    = digit_run();
      pointed = $urandom_range(0, 1);
      nfrac   = pointed ? digit_run() : 0;
      if (nint + nfrac == 0) nint = 1;
      put_digits(nint);
      if (pointed) begin
         put_text(".");
         put_digits(nfrac);
      end
      put_text($urandom_range(0, 1) ? "p" : "P");
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         case ($urandom_range(0, 2))
            1: put_text("+");
            2: put_text("-");
            default: ;
         endcase
         put_text($sformatf("%0d", $urandom_range(0, 40)));
      end else if (kind < 6) begin
         if ($urandom_range(0, 1)) put_text("+");
         put_text($sformatf("%0d", (dbl ? 1024 : 128) + $urandom_range(0, 30) - 25));
      end else if (kind < 8) begin
         put_text("-");
         put_text($sformatf("%0d", (dbl ? 1074 : 149) + $urandom_range(0, 40) - 80));
      end else if (kind == 8) begin
         if ($urandom_range(0, 1)) put_text("-");
         put_text($sformatf("%0d", $urandom_range(100, 99999)));
      end else begin
         if ($urandom_range(0, 1)) put_text("-");
         put_hex($urandom_range(1, 9));
         repeat ($urandom_range(7, 11)) put_hex($urandom_range(0, 9));
      end
      case ($urandom_range(0, 5))
         1: put_text("f");
         2: put_text("F");
         3: put_text("d");
         4: put_text("D");
         default: ;
      endcase
      repeat ($urandom_range(0, 2)) draft.push_back(8'($urandom_range(0, 32)));
   endtask

   task automatic queue_directed();
      string lits[] = '{
         " 0x1p0", "-0X1.8P+1", "+0x.8p-1d", "\t0xFFFFFFFFFFFFFFFFFFFFp0F ",
         "0x1.fffffffffffff8p0", "0x1.00000000000008p0", "0x1.000001p0", "-0x0.0p5",
         "0x1p1024", "0x1.ffffffffffffffp1023", "0x1p-1074", "0x1p-1075", "0x1p-1080",
         "0x1P+127f", "0x1.ffffffp127", "0x1p-149", "0x7p-151", "0x1p99999999999",
         "-0x1p-99999999999D", "0xAbCdEf.9p-7 ", "0x1p", "0x.p1", "0x1.2.3p0",
         "0x1p1ff", "-"
      };
      foreach (lits[i]) begin
         put_text(lits[i]);
         commit();
      end
      // whitespace down to the NUL byte ahead of the literal
      draft.push_back(8'h00);
      put_text("0x3p2");
      commit();
   endtask

   // Hold until every word has gone through and the pipeline has emptied
   task automatic wait_idle();
      while (pending_chars.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_mode(logic dbl);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dbl;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      fp_double = dbl;
      @(negedge clock);
   endtask

   initial begin
      int   phase_chars;
      int   idx;
      logic dbl;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed literals in both formats, binary64 first from reset
      queue_directed();
      wait_idle();
      write_mode(1'b0);
      queue_directed();
      wait_idle();

      // random phases, alternating formats
      for (int p = 0; p < 8; p++) begin
         dbl = p[0];
         write_mode(dbl);
         phase_chars = 0;
         while (phase_chars < 50) begin
            case ($urandom_range(0, 9))
               0: begin
                  repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom_range(0, 255)));
               end
               1: begin
                  draft_literal(dbl);
                  idx = $urandom_range(0, draft.size() - 1);
                  if ($urandom_range(0, 1) && draft.size() > 1)
                     repeat ($urandom_range(1, draft.size() - 1)) void'(draft.pop_back());
                  else
                     draft[idx] = 8'($urandom_range(0, 255));
               end
               default: draft_literal(dbl);
            endcase
            phase_chars += draft.size();
            commit();
         end
         wait_idle();
      end

      if (mismatches == 0)
         $display("hex_float_string_to_bits regression: pass");
      else
         $display("hex_float_string_to_bits regression: fail");
      $finish;
   end

endmodule

// ----- hex_float_string_to_bits.f -----
rtl/hfs_pkg.sv
rtl/hfs_parse.sv
rtl/hfs_align.sv
rtl/hfs_round.sv
rtl/hex_float_string_to_bits.sv
tb/hex_float_string_to_bits_tb.sv
